FILE: hw/rtl/gbom_pkg.sv
// ----------------------------------------------------------------------------
// gbom_pkg
// Shared types and constants of the greedy box overlap matcher.
// ----------------------------------------------------------------------------
package gbom_pkg;

	// Coordinate and derived arithmetic widths.
	localparam int COORD_WIDTH = 16;
	localparam int GEO_W       = COORD_WIDTH + 2;
	localparam int DIM_W       = COORD_WIDTH + 1;
	localparam int AREA_W      = 2 * DIM_W;
	localparam int MULP_W      = DIM_W + AREA_W;
	localparam int PROD_W      = 2 * AREA_W;
	localparam int THR_W       = 17;
	localparam int THR_FRAC_W  = 16;
	localparam int CNT32_W     = 32;
	localparam int INDEX_W     = 6;

	// Default store depth.
	localparam int MAX_PRED_DEFAULT = 64;

	// Register file.
	localparam int          APB_ADDR_W = 3;
	localparam logic        REG_MODE   = 1'b0;
	localparam logic        REG_THR    = 1'b1;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(45875);

	// Request commands.
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_GT    = 2'd2;
	localparam logic [1:0] CMD_RESET = 2'd3;

	// One stored box.
	typedef struct packed {
		logic [COORD_WIDTH-1:0] left;
		logic [COORD_WIDTH-1:0] top;
		logic [COORD_WIDTH-1:0] width;
		logic [COORD_WIDTH-1:0] height;
	} box_t;

	// Control of the prediction store.
	typedef struct packed {
		logic box_we;
		logic unm_we;
		logic unm_val;
		logic rd_en;
	} store_ctl_t;

endpackage

FILE: hw/rtl/gbom_if.sv
// ----------------------------------------------------------------------------
// gbom_if
// Request and result channels of the greedy box overlap matcher.
// ----------------------------------------------------------------------------
interface gbom_req_if
	import gbom_pkg::*;
	();
	logic                   valid;
	logic                   ready;
	logic [1:0]             cmd;
	logic [COORD_WIDTH-1:0] box_x;
	logic [COORD_WIDTH-1:0] box_y;
	logic [COORD_WIDTH-1:0] box_w;
	logic [COORD_WIDTH-1:0] box_h;

	modport source (output valid, cmd, box_x, box_y, box_w, box_h, input ready);
	modport sink (input valid, cmd, box_x, box_y, box_w, box_h, output ready);
endinterface

interface gbom_res_if
	import gbom_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic               hit;
	logic               candidate_found;
	logic [INDEX_W-1:0] matched_index;
	logic [CNT32_W-1:0] total_count;
	logic [CNT32_W-1:0] hit_count;

	modport source (output valid, hit, candidate_found, matched_index, total_count,
		hit_count, input ready);
	modport sink (input valid, hit, candidate_found, matched_index, total_count,
		hit_count, output ready);
endinterface

FILE: hw/rtl/gbom_store.sv
// ----------------------------------------------------------------------------
// gbom_store
// Prediction store: box geometry and an unmatched mark per entry, one write
// port for each and one registered read port.
// ----------------------------------------------------------------------------
module gbom_store
	import gbom_pkg::*;
#(
	parameter int MAX_PREDICTIONS = MAX_PRED_DEFAULT,
	parameter int IDX_W = (MAX_PREDICTIONS > 1) ? $clog2(MAX_PREDICTIONS) : 1
) (
	input  logic             clk,
	input  store_ctl_t       ctl,
	input  logic [IDX_W-1:0] box_idx,
	input  box_t             box_wdata,
	input  logic [IDX_W-1:0] unm_idx,
	input  logic [IDX_W-1:0] rd_idx,
	output box_t             rd_box,
	output logic             rd_unm
);

	box_t mem_box [MAX_PREDICTIONS];
	logic mem_unm [MAX_PREDICTIONS];
	box_t rd_box_q;
	logic rd_unm_q;

	// Writes and the registered read.
	always_ff @(posedge clk) begin
		if (ctl.box_we) begin
			mem_box[box_idx] <= box_wdata;
		end
		if (ctl.unm_we) begin
			mem_unm[unm_idx] <= ctl.unm_val;
		end
		if (ctl.rd_en) begin
			rd_box_q <= mem_box[rd_idx];
			rd_unm_q <= mem_unm[rd_idx];
		end
	end

	assign rd_box = rd_box_q;
	assign rd_unm = rd_unm_q;

endmodule

FILE: hw/rtl/greedy_box_overlap_matcher_core.sv
// ----------------------------------------------------------------------------
// greedy_box_overlap_matcher_core
// Greedy overlap matching of ground-truth boxes against stored predictions,
// using one shared 17 x 34 bit multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Clear, load and counter-reset requests are handled in the idle state. A
// ground-truth request reads the stored entries in turn through the single
// store read port, skips matched ones, forms area, intersection and (in
// bounding-rectangle mode) union of each unmatched one on the shared
// multiplier and compares it with the best so far; new requests are taken only in idle, after the result is registered.
// Reset is asynchronous: it empties the store, zeroes the counters and loads
// the register reset values. The block takes requests right after reset.
module greedy_box_overlap_matcher_core
	import gbom_pkg::*;
#(
	parameter int MAX_PREDICTIONS = MAX_PRED_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	gbom_req_if.sink              req,
	gbom_res_if.source            res
);

	localparam int IDX_W = (MAX_PREDICTIONS > 1) ? $clog2(MAX_PREDICTIONS) : 1;
	localparam int CNT_W = $clog2(MAX_PREDICTIONS + 1);
	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(MAX_PREDICTIONS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_AREA_B, ST_FETCH, ST_READ, ST_MUL_A, ST_MUL_I, ST_MUL_U,
		ST_PICK, ST_C0, ST_C1, ST_C2, ST_C3, ST_THR, ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic             mode_q;
	logic [THR_W-1:0] thr_q;

	// Store bookkeeping and request registers.
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] j_q;
	box_t             gt_q;

	// Scan datapath registers.
	logic [DIM_W-1:0]  iw_q, ih_q, uw_q, uh_q;
	logic [AREA_W-1:0] area_b_q, area_a_q, inter_q, union_q;
	logic [AREA_W-1:0] cur_n_q, cur_d_q, best_n_q, best_d_q;
	logic [PROD_W-1:0] acc_q, p1_q;
	logic [IDX_W-1:0]  best_q;
	logic              found_q, hit_q;

	// Counters and result registers.
	logic [CNT32_W-1:0] total_q, hits_q;
	logic               res_valid_q, res_hit_q, res_found_q;
	logic [INDEX_W-1:0] res_index_q;
	logic [CNT32_W-1:0] res_total_q, res_hits_q;

	// Store port.
	store_ctl_t store_ctl;
	logic [IDX_W-1:0] unm_idx;
	box_t rd_box;
	logic rd_unm;

	// Shared multiplier.
	logic [DIM_W-1:0]  mul_a;
	logic [AREA_W-1:0] mul_b;
	logic [MULP_W-1:0] mul_p;

	// Geometry and selection signals.
	logic signed [GEO_W-1:0] ax, ay, bx, by, a_xe, a_ye, b_xe, b_ye;
	logic signed [GEO_W-1:0] iw, ih, uw, uh;
	logic [AREA_W-1:0] d_sel, n_pick, d_pick;
	logic [PROD_W-1:0] p2_sum;
	logic [PROD_W-1:0] thr_lhs;
	logic [IDX_W+INDEX_W-1:0] best_ext;
	logic req_fire, emit, out_free;

	assign req_fire = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !res_valid_q || res.ready;
	assign emit = (state_q == ST_DONE) && out_free;

	// APB register port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THR) ? 32'(thr_q) : 32'(mode_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			thr_q  <= THR_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_MODE) begin
				mode_q <= pwdata[0];
			end else begin
				thr_q <= pwdata[THR_W-1:0];
			end
		end
	end

	// Store control: loads in idle, clearing the mark of a hit at the end.
	always_comb begin
		store_ctl.box_we  = req_fire && (req.cmd == CMD_LOAD) && (fill_q < FILL_MAX);
		store_ctl.unm_we  = store_ctl.box_we || (emit && hit_q);
		store_ctl.unm_val = store_ctl.box_we;
		store_ctl.rd_en   = (state_q == ST_FETCH) && (j_q < fill_q);
		unm_idx = store_ctl.box_we ? fill_q[IDX_W-1:0] : best_q;
	end

	gbom_store #(
		.MAX_PREDICTIONS(MAX_PREDICTIONS),
		.IDX_W(IDX_W)
	) u_store (
		.clk      (clk),
		.ctl      (store_ctl),
		.box_idx  (fill_q[IDX_W-1:0]),
		.box_wdata({req.box_x, req.box_y, req.box_w, req.box_h}),
		.unm_idx  (unm_idx),
		.rd_idx   (j_q[IDX_W-1:0]),
		.rd_box   (rd_box),
		.rd_unm   (rd_unm)
	);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			ST_AREA_B: begin
				mul_a = DIM_W'(gt_q.width);
				mul_b = AREA_W'(gt_q.height);
			end
			ST_MUL_A: begin
				mul_a = DIM_W'(rd_box.width);
				mul_b = AREA_W'(rd_box.height);
			end
			ST_MUL_I: begin
				mul_a = iw_q;
				mul_b = AREA_W'(ih_q);
			end
			ST_MUL_U: begin
				mul_a = uw_q;
				mul_b = AREA_W'(uh_q);
			end
			ST_C0: begin
				mul_a = cur_n_q[DIM_W-1:0];
				mul_b = best_d_q;
			end
			ST_C1: begin
				mul_a = cur_n_q[AREA_W-1:DIM_W];
				mul_b = best_d_q;
			end
			ST_C2: begin
				mul_a = best_n_q[DIM_W-1:0];
				mul_b = cur_d_q;
			end
			ST_C3: begin
				mul_a = best_n_q[AREA_W-1:DIM_W];
				mul_b = cur_d_q;
			end
			ST_THR: begin
				mul_a = DIM_W'(thr_q);
				mul_b = best_d_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = MULP_W'(mul_a) * MULP_W'(mul_b);

	// Edges, intersection and bounding extents of the stored and the new box.
	always_comb begin
		ax   = GEO_W'(signed'(rd_box.left));
		ay   = GEO_W'(signed'(rd_box.top));
		bx   = GEO_W'(signed'(gt_q.left));
		by   = GEO_W'(signed'(gt_q.top));
		a_xe = ax + signed'(GEO_W'(rd_box.width));
		a_ye = ay + signed'(GEO_W'(rd_box.height));
		b_xe = bx + signed'(GEO_W'(gt_q.width));
		b_ye = by + signed'(GEO_W'(gt_q.height));
		iw = ((a_xe < b_xe) ? a_xe : b_xe) - ((ax > bx) ? ax : bx);
		ih = ((a_ye < b_ye) ? a_ye : b_ye) - ((ay > by) ? ay : by);
		uw = ((a_xe > b_xe) ? a_xe : b_xe) - ((ax < bx) ? ax : bx);
		uh = ((a_ye > b_ye) ? a_ye : b_ye) - ((ay < by) ? ay : by);
	end

	// Overlap fraction of the current entry; a zero denominator reads 0/1.
	always_comb begin
		if (!mode_q) begin
			d_sel = (area_a_q > area_b_q) ? area_a_q : area_b_q;
		end else if (area_a_q == '0) begin
			d_sel = area_b_q;
		end else if (area_b_q == '0) begin
			d_sel = area_a_q;
		end else begin
			d_sel = union_q;
		end
		if (d_sel == '0) begin
			n_pick = '0;
			d_pick = AREA_W'(1);
		end else begin
			n_pick = inter_q;
			d_pick = d_sel;
		end
	end

	assign p2_sum   = acc_q + (PROD_W'(mul_p) << DIM_W);
	assign thr_lhs  = PROD_W'(best_n_q) << THR_FRAC_W;
	assign best_ext = {{INDEX_W{1'b0}}, best_q};

	// Sequencer with its datapath and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			j_q         <= '0;
			found_q     <= 1'b0;
			hit_q       <= 1'b0;
			total_q     <= '0;
			hits_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (req.cmd)
							CMD_CLEAR: fill_q <= '0;
							CMD_LOAD: begin
								if (fill_q < FILL_MAX) begin
									fill_q <= fill_q + CNT_W'(1);
								end
							end
							CMD_RESET: begin
								total_q <= '0;
								hits_q  <= '0;
							end
							default: begin
								gt_q    <= {req.box_x, req.box_y, req.box_w, req.box_h};
								j_q     <= '0;
								found_q <= 1'b0;
								hit_q   <= 1'b0;
								best_q  <= '0;
								state_q <= ST_AREA_B;
							end
						endcase
					end
				end
				ST_AREA_B: begin
					area_b_q <= mul_p[AREA_W-1:0];
					state_q  <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= (j_q < fill_q) ? ST_READ : ST_THR;
				end
				ST_READ: begin
					if (!rd_unm) begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= ST_FETCH;
					end else begin
						if (iw > 0 && ih > 0) begin
							iw_q <= iw[DIM_W-1:0];
							ih_q <= ih[DIM_W-1:0];
						end else begin
							iw_q <= '0;
							ih_q <= '0;
						end
						uw_q    <= uw[DIM_W-1:0];
						uh_q    <= uh[DIM_W-1:0];
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: begin
					area_a_q <= mul_p[AREA_W-1:0];
					state_q  <= ST_MUL_I;
				end
				ST_MUL_I: begin
					inter_q <= mul_p[AREA_W-1:0];
					state_q <= mode_q ? ST_MUL_U : ST_PICK;
				end
				ST_MUL_U: begin
					union_q <= mul_p[AREA_W-1:0];
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (!found_q) begin
						found_q  <= 1'b1;
						best_q   <= j_q[IDX_W-1:0];
						best_n_q <= n_pick;
						best_d_q <= d_pick;
						j_q      <= j_q + CNT_W'(1);
						state_q  <= ST_FETCH;
					end else begin
						cur_n_q <= n_pick;
						cur_d_q <= d_pick;
						state_q <= ST_C0;
					end
				end
				ST_C0: begin
					acc_q   <= PROD_W'(mul_p);
					state_q <= ST_C1;
				end
				ST_C1: begin
					p1_q    <= p2_sum;
					state_q <= ST_C2;
				end
				ST_C2: begin
					acc_q   <= PROD_W'(mul_p);
					state_q <= ST_C3;
				end
				ST_C3: begin
					// Strictly greater keeps the first entry on ties.
					if (p1_q > p2_sum) begin
						best_q   <= j_q[IDX_W-1:0];
						best_n_q <= cur_n_q;
						best_d_q <= cur_d_q;
					end
					j_q     <= j_q + CNT_W'(1);
					state_q <= ST_FETCH;
				end
				ST_THR: begin
					hit_q   <= found_q && (thr_lhs > PROD_W'(mul_p));
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_hit_q   <= hit_q;
						res_found_q <= found_q;
						res_index_q <= found_q ? best_ext[INDEX_W-1:0] : '0;
						res_total_q <= (total_q != '1) ? total_q + 32'd1 : total_q;
						res_hits_q  <= (hit_q && hits_q != '1) ? hits_q + 32'd1 : hits_q;
						if (total_q != '1) begin
							total_q <= total_q + 32'd1;
						end
						if (hit_q && hits_q != '1) begin
							hits_q <= hits_q + 32'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid           = res_valid_q;
	assign res.hit             = res_hit_q;
	assign res.candidate_found = res_found_q;
	assign res.matched_index   = res_index_q;
	assign res.total_count     = res_total_q;
	assign res.hit_count       = res_hits_q;

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Greedy box overlap matcher regression
// Drives clear, load, ground-truth and counter-reset requests through the
// request channel under random idling. An in-bench predictor holds its own
// copy of the prediction store, the counters and the registers. Every result
// is checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;
	import gbom_pkg::*;

	localparam logic [APB_ADDR_W-1:0] ADDR_MODE = APB_ADDR_W'(0);
	localparam logic [APB_ADDR_W-1:0] ADDR_THR  = APB_ADDR_W'(4);
	localparam int DEPTH     = MAX_PRED_DEFAULT;
	localparam int SETTLE    = 30;
	localparam int RAND_REQS = 900;

	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
	} box_req_t;

	typedef struct {
		logic        hit;
		logic        found;
		logic [5:0]  index;
		logic [31:0] total;
		logic [31:0] hits;
	} match_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	gbom_req_if req ();
	gbom_res_if res ();

	greedy_box_overlap_matcher_core dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req), .res(res)
	);

	always #5 clk = ~clk;

	// Shadow copy of the block state.
	logic [15:0] pred_x [DEPTH];
	logic [15:0] pred_y [DEPTH];
	logic [15:0] pred_w [DEPTH];
	logic [15:0] pred_h [DEPTH];
	bit          pred_open [DEPTH];
	int          pred_count;
	bit          cfg_mode;
	logic [16:0] cfg_thr;
	logic [31:0] gt_seen, gt_hit;

	match_t expected_matches[$];
	int errors, requests_sent, results_checked, hits_seen;
	bit idle_on, stall_on;

	function automatic longint lmin(longint a, longint b);
		return a < b ? a : b;
	endfunction

	function automatic longint lmax(longint a, longint b);
		return a > b ? a : b;
	endfunction

	// True if a*b > c*d, exact.
	function automatic bit prod_gt(logic [63:0] a, logic [63:0] b, logic [63:0] c,
		logic [63:0] d);
		logic [127:0] p, q;
		p = {64'd0, a} * {64'd0, b};
		q = {64'd0, c} * {64'd0, d};
		return p > q;
	endfunction

	// Overlap of stored entry j with box r as num/den.
	function automatic void overlap(int j, box_req_t r, output logic [63:0] num,
		output logic [63:0] den);
		longint ax, ay, aw, ah, bx, by, bw, bh, iw, ih, inter, aa, ab, d;
		ax = longint'($signed(pred_x[j]));
		ay = longint'($signed(pred_y[j]));
		aw = longint'(pred_w[j]);
		ah = longint'(pred_h[j]);
		bx = longint'($signed(r.x));
		by = longint'($signed(r.y));
		bw = longint'(r.w);
		bh = longint'(r.h);
		aa = aw * ah;
		ab = bw * bh;
		iw = lmin(ax + aw, bx + bw) - lmax(ax, bx);
		ih = lmin(ay + ah, by + bh) - lmax(ay, by);
		inter = (iw > 0 && ih > 0) ? iw * ih : 0;
		if (!cfg_mode) d = lmax(aa, ab);
		else if (aa == 0) d = ab;
		else if (ab == 0) d = aa;
		else d = (lmax(ax + aw, bx + bw) - lmin(ax, bx)) *
			(lmax(ay + ah, by + bh) - lmin(ay, by));
		if (d == 0) begin
			num = 0;
			den = 1;
		end else begin
			num = inter;
			den = d;
		end
	endfunction

	// Applies one accepted request to the shadow state.
	function automatic void predict_match(box_req_t r);
		match_t m;
		logic [63:0] n, d, bn, bd;
		int best;
		bit found;
		case (r.cmd)
			CMD_CLEAR: begin
				foreach (pred_open[i]) pred_open[i] = 0;
				pred_count = 0;
			end
			CMD_LOAD: begin
				if (pred_count < DEPTH) begin
					pred_x[pred_count] = r.x;
					pred_y[pred_count] = r.y;
					pred_w[pred_count] = r.w;
					pred_h[pred_count] = r.h;
					pred_open[pred_count] = 1;
					pred_count++;
				end
			end
			CMD_RESET: begin
				gt_seen = 0;
				gt_hit = 0;
			end
			default: begin
				found = 0;
				best = 0;
				bn = 0;
				bd = 1;
				for (int j = 0; j < pred_count; j++) begin
					if (!pred_open[j]) continue;
					overlap(j, r, n, d);
					if (!found || prod_gt(n, bd, bn, d)) begin
						found = 1;
						best = j;
						bn = n;
						bd = d;
					end
				end
				m.hit = found && prod_gt(bn, 64'd65536, 64'(cfg_thr), bd);
				if (m.hit) begin
					pred_open[best] = 0;
					if (gt_hit != '1) gt_hit++;
				end
				if (gt_seen != '1) gt_seen++;
				m.found = found;
				m.index = found ? 6'(best) : 6'd0;
				m.total = gt_seen;
				m.hits = gt_hit;
				expected_matches.push_back(m);
			end
		endcase
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// Result side: random stalls, changed at the falling edge.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			res.ready = stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
			if (stall_on && $urandom_range(0, 60) == 0) begin
				res.ready = 1'b0;
				repeat ($urandom_range(10, 50)) @(negedge clk);
			end
		end
	end

	// Checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			match_t e;
			if (expected_matches.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				e = expected_matches.pop_front();
				results_checked++;
				if (res.hit) hits_seen++;
				if (res.hit !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, res.hit);
					errors++;
				end
				if (res.candidate_found !== e.found) begin
					$error("candidate_found: expected %0d, got %0d", e.found,
						res.candidate_found);
					errors++;
				end
				if (res.matched_index !== e.index) begin
					$error("matched_index: expected %0d, got %0d", e.index,
						res.matched_index);
					errors++;
				end
				if (res.total_count !== e.total) begin
					$error("total_count: expected %0d, got %0d", e.total,
						res.total_count);
					errors++;
				end
				if (res.hit_count !== e.hits) begin
					$error("hit_count: expected %0d, got %0d", e.hits, res.hit_count);
					errors++;
				end
			end
		end
	end

	// Sends one request and updates the shadow state once it is accepted.
	task automatic send_box(logic [1:0] cmd, logic [15:0] x, logic [15:0] y,
		logic [15:0] w, logic [15:0] h);
		box_req_t r;
		int g;
		r = '{cmd, x, y, w, h};
		g = idle_on ? gap_len() : 0;
		if (g > 0) begin
			@(negedge clk);
			req.valid = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid = 1'b1;
		req.cmd = cmd;
		req.box_x = x;
		req.box_y = y;
		req.box_w = w;
		req.box_h = h;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_match(r);
		requests_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid = 1'b0;
		while (expected_matches.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Writes both registers while the block is idle.
	task automatic set_config(bit mode, logic [16:0] thr);
		drain();
		apb_write(ADDR_MODE, 32'(mode));
		cfg_mode = mode;
		apb_write(ADDR_THR, 32'(thr));
		cfg_thr = thr;
	endtask

	// A random box: mostly small and close to the origin, sometimes anything.
	task automatic random_box(logic [1:0] cmd);
		if ($urandom_range(0, 9) == 0)
			send_box(cmd, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		else
			send_box(cmd, 16'($urandom_range(0, 400) - 200), 16'($urandom_range(0, 400) - 200),
				16'($urandom_range(0, 120)), 16'($urandom_range(0, 120)));
	endtask

	// A ground-truth box near a stored prediction, so that hits occur.
	task automatic near_box(int j);
		send_box(CMD_GT, pred_x[j] + 16'($urandom_range(0, 6) - 3),
			pred_y[j] + 16'($urandom_range(0, 6) - 3),
			pred_w[j] + 16'($urandom_range(0, 6) - 3),
			pred_h[j] + 16'($urandom_range(0, 6) - 3));
	endtask

	// Corner cases in larger-area mode with the reset threshold.
	task automatic test_directed_edges();
		send_box(CMD_GT, 16'd0, 16'd0, 16'd10, 16'd10);         // empty store
		send_box(CMD_LOAD, 16'd0, 16'd0, 16'd10, 16'd10);
		send_box(CMD_LOAD, 16'd5, 16'd5, 16'd0, 16'd10);         // zero width
		send_box(CMD_LOAD, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
		send_box(CMD_LOAD, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
		send_box(CMD_LOAD, 16'd0, 16'd0, 16'd10, 16'd10);        // tie with entry 0
		send_box(CMD_GT, 16'd0, 16'd0, 16'd10, 16'd10);
		send_box(CMD_GT, 16'd0, 16'd0, 16'd10, 16'd10);
		send_box(CMD_GT, 16'd0, 16'd0, 16'd10, 16'd10);
		send_box(CMD_GT, 16'd5, 16'd5, 16'd0, 16'd0);            // zero denominator
		send_box(CMD_GT, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
		send_box(CMD_GT, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
		send_box(CMD_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_box(CMD_GT, 16'd1, 16'd1, 16'd9, 16'd9);
		send_box(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_box(CMD_GT, 16'd1, 16'd1, 16'd9, 16'd9);
	endtask

	// Same frame under both overlap modes and threshold extremes.
	task automatic test_modes_and_thresholds();
		logic [16:0] thr_list [4] = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768};
		foreach (thr_list[t]) begin
			set_config(t % 2 == 0, thr_list[t]);
			send_box(CMD_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0);
			send_box(CMD_LOAD, 16'd0, 16'd0, 16'd20, 16'd20);
			send_box(CMD_LOAD, 16'd10, 16'd0, 16'd0, 16'd20);
			send_box(CMD_GT, 16'd0, 16'd0, 16'd20, 16'd20);
			send_box(CMD_GT, 16'd5, 16'd5, 16'd20, 16'd20);
		end
	endtask

	// Random frames: clear, loads, ground-truth boxes, some noise.
	task automatic test_random_frames();
		int k, m, start;
		start = requests_sent;
		while (requests_sent - start < RAND_REQS) begin
			if ((requests_sent - start) % 200 < 10 && requests_sent - start > 0) begin
				set_config($urandom_range(0, 1), ($urandom_range(0, 3) == 0) ?
					17'($urandom_range(65536, 131071)) : 17'($urandom_range(0, 65536)));
				idle_on = $urandom_range(0, 2) != 0;
				stall_on = $urandom_range(0, 2) != 0;
			end
			send_box(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			k = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 10);
			repeat (k) random_box(CMD_LOAD);
			m = $urandom_range(1, (k > 12) ? 8 : k + 3);
			repeat (m) begin
				if ($urandom_range(0, 19) == 0)
					random_box(2'($urandom_range(0, 3)));
				else if (pred_count > 0 && $urandom_range(0, 9) < 7)
					near_box($urandom_range(0, pred_count - 1));
				else
					random_box(CMD_GT);
			end
			// Now and then hold back until every result has come.
			if ($urandom_range(0, 9) == 0) begin
				@(negedge clk);
				req.valid = 1'b0;
				while (expected_matches.size() != 0) @(posedge clk);
			end
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.cmd = CMD_CLEAR;
		req.box_x = '0;
		req.box_y = '0;
		req.box_w = '0;
		req.box_h = '0;
		foreach (pred_open[i]) pred_open[i] = 0;
		pred_count = 0;
		cfg_mode = 0;
		cfg_thr = THR_RESET;
		gt_seen = 0;
		gt_hit = 0;
		idle_on = 1;
		stall_on = 1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		set_config(1'b0, THR_RESET);
		test_directed_edges();
		test_modes_and_thresholds();
		test_random_frames();
		drain();
		if (expected_matches.size() != 0) errors++;
		$display("Sent %0d requests; checked %0d ground-truth results, %0d of them hits.",
			requests_sent, results_checked, hits_seen);
		$display("Both overlap modes and thresholds from zero to out of range were used.");
		if (errors == 0)
			$display("greedy_box_overlap_matcher_core regression: pass");
		else
			$display("greedy_box_overlap_matcher_core regression: fail");
		$finish;
	end

	// Run limit.
	initial begin
		#40000000;
		$display("greedy_box_overlap_matcher_core regression: fail");
		$finish;
	end

endmodule
